/* src/meter_frame_sync_deframer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the meter frame deframer checkers
// Clocked concurrent assertion shorthands on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef METER_FRAME_SYNC_DEFRAMER_MACROS_SVH
`define METER_FRAME_SYNC_DEFRAMER_MACROS_SVH

// same-cycle implication, off while reset is low
`define MFSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is low
`define MFSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, live through reset
`define MFSD_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/mfsd_pkg.sv */
// ----------------------------------------------------------------------------
// mfsd_pkg
// Shared constants and types of the meter frame deframer.
// ----------------------------------------------------------------------------
package mfsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POWER_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 3;

  localparam logic [BYTE_W-1:0] PRE0       = 8'h24;
  localparam logic [BYTE_W-1:0] PRE1       = 8'h56;
  localparam logic [BYTE_W-1:0] CHECK_BASE = 8'hFF;

  localparam logic [STATUS_W-1:0] ST_GOOD = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CSUM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SYNC = 2'd2;

  localparam logic [POS_W-1:0] POS_START = 3'd0;
  localparam logic [POS_W-1:0] POS_PRE1  = 3'd1;
  localparam logic [POS_W-1:0] POS_BODY  = 3'd2;
  localparam logic [POS_W-1:0] POS_PWRH  = 3'd4;
  localparam logic [POS_W-1:0] POS_PWRL  = 3'd5;
  localparam logic [POS_W-1:0] POS_CHECK = 3'd7;

  typedef struct packed {
    logic                vld;
    logic [POWER_W-1:0]  power;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

/* src/mfsd_in_reg.sv */
// ----------------------------------------------------------------------------
// mfsd_in_reg
// Input register: holds one received byte until the frame core takes it.
// ----------------------------------------------------------------------------
module mfsd_in_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mfsd_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                         take,
  output logic                         byte_vld,
  output logic [mfsd_pkg::BYTE_W-1:0]  byte_val
);

  logic                        vld_r, vld_nxt;
  logic [mfsd_pkg::BYTE_W-1:0] byte_r;

  assign in_ready = !vld_r || take;
  assign byte_vld = vld_r;
  assign byte_val = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

/* src/mfsd_core.sv */
// ----------------------------------------------------------------------------
// mfsd_core
// Frame tracker: preamble hunt, byte position, checksum and power capture.
// ----------------------------------------------------------------------------
module mfsd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [mfsd_pkg::BYTE_W-1:0]  b,
  output mfsd_pkg::res_t               res
);

  logic                          locked_r, locked_nxt;
  logic [mfsd_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [mfsd_pkg::BYTE_W-1:0]   prev_r, prev_nxt;
  logic [mfsd_pkg::BYTE_W-1:0]   sum_r, sum_nxt;
  logic [mfsd_pkg::POWER_W-1:0]  pwr_r, pwr_nxt;
  logic [mfsd_pkg::BYTE_W-1:0]   expected;

  assign expected = mfsd_pkg::CHECK_BASE - sum_r;

  always_comb begin
    locked_nxt = locked_r;
    pos_nxt    = pos_r;
    prev_nxt   = b;
    sum_nxt    = sum_r;
    pwr_nxt    = pwr_r;
    res.vld    = 1'b0;
    res.power  = '0;
    res.status = mfsd_pkg::ST_GOOD;
    if (!locked_r) begin
      if (prev_r == mfsd_pkg::PRE0 && b == mfsd_pkg::PRE1) begin
        locked_nxt = 1'b1;
        pos_nxt    = mfsd_pkg::POS_BODY;
        sum_nxt    = b;
        pwr_nxt    = '0;
      end else begin
        pos_nxt = mfsd_pkg::POS_START;
      end
    end else begin
      case (pos_r)
        mfsd_pkg::POS_START: begin
          sum_nxt = '0;
          pos_nxt = mfsd_pkg::POS_PRE1;
        end
        mfsd_pkg::POS_PRE1: begin
          if (prev_r != mfsd_pkg::PRE0 || b != mfsd_pkg::PRE1) begin
            // drop lock and restart the hunt from this byte
            locked_nxt = 1'b0;
            pos_nxt    = mfsd_pkg::POS_START;
            sum_nxt    = '0;
            res.vld    = 1'b1;
            res.status = mfsd_pkg::ST_SYNC;
          end else begin
            sum_nxt = b;
            pos_nxt = mfsd_pkg::POS_BODY;
          end
        end
        mfsd_pkg::POS_CHECK: begin
          pos_nxt = mfsd_pkg::POS_START;
          res.vld = 1'b1;
          if (b == expected) begin
            res.power = pwr_r;
          end else begin
            res.status = mfsd_pkg::ST_CSUM;
          end
        end
        default: begin
          sum_nxt = sum_r + b;
          if (pos_r == mfsd_pkg::POS_PWRH) begin
            pwr_nxt = {b, pwr_r[mfsd_pkg::BYTE_W-1:0]};
          end else if (pos_r == mfsd_pkg::POS_PWRL) begin
            pwr_nxt = {pwr_r[mfsd_pkg::POWER_W-1:mfsd_pkg::BYTE_W], b};
          end
          pos_nxt = pos_r + 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      pos_r    <= mfsd_pkg::POS_START;
      prev_r   <= '0;
      sum_r    <= '0;
      pwr_r    <= '0;
    end else if (step) begin
      locked_r <= locked_nxt;
      pos_r    <= pos_nxt;
      prev_r   <= prev_nxt;
      sum_r    <= sum_nxt;
      pwr_r    <= pwr_nxt;
    end
  end

endmodule

/* src/mfsd_out_reg.sv */
// ----------------------------------------------------------------------------
// mfsd_out_reg
// Result register: holds one frame result until the consumer takes it.
// ----------------------------------------------------------------------------
module mfsd_out_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  mfsd_pkg::res_t                 res,
  output logic                           free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mfsd_pkg::POWER_W-1:0]   out_power_watts,
  output logic [mfsd_pkg::STATUS_W-1:0]  out_frame_status
);

  logic                          vld_r, vld_nxt;
  logic [mfsd_pkg::POWER_W-1:0]  power_r;
  logic [mfsd_pkg::STATUS_W-1:0] status_r;

  assign free             = !vld_r || out_ready;
  assign out_valid        = vld_r;
  assign out_power_watts  = power_r;
  assign out_frame_status = status_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      power_r  <= res.power;
      status_r <= res.status;
    end
  end

endmodule

/* src/meter_frame_sync_deframer.sv */
// ----------------------------------------------------------------------------
// meter_frame_sync_deframer
// Serial power meter frame deframer: one request per received byte, one
// result request per completed or broken frame.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, sustained, for as long as the result side
// keeps up; a byte waits in the input register until the tracker takes it,
// and its result, if any, is loaded into the result register as it is taken.
// The rate is set by the frame tracker's update of position, running sum and
// power bytes for each byte taken. After reset the block hunts for the 0x24
// 0x56 preamble and emits nothing until it has locked; each 8-byte frame then
// yields one result: status 0 with the power, status 1 on a checksum
// mismatch, or status 2 when the preamble is missing and the hunt restarts.
module meter_frame_sync_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mfsd_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mfsd_pkg::POWER_W-1:0]   out_power_watts,
  output logic [mfsd_pkg::STATUS_W-1:0]  out_frame_status
);

  logic                        byte_vld;
  logic [mfsd_pkg::BYTE_W-1:0] byte_val;
  logic                        out_free;
  logic                        take;
  mfsd_pkg::res_t              res;

  assign take = byte_vld && out_free;

  mfsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .byte_vld   (byte_vld),
    .byte_val   (byte_val)
  );

  mfsd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .b     (byte_val),
    .res   (res)
  );

  mfsd_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (take && res.vld),
    .res              (res),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power_watts  (out_power_watts),
    .out_frame_status (out_frame_status)
  );

endmodule

/* src/mfsd_checker.sv */
// ----------------------------------------------------------------------------
// mfsd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "meter_frame_sync_deframer_macros.svh"

module mfsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [mfsd_pkg::BYTE_W-1:0]    in_rx_byte,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mfsd_pkg::POWER_W-1:0]   out_power_watts,
  input logic [mfsd_pkg::STATUS_W-1:0]  out_frame_status
);

  `MFSD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_rx_byte), "input request dropped or changed while stalled")
  `MFSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_power_watts) && $stable(out_frame_status), "result request dropped or changed while stalled")
  `MFSD_ASSERT_NOW(a_status_code, out_valid, out_frame_status == mfsd_pkg::ST_GOOD || out_frame_status == mfsd_pkg::ST_CSUM || out_frame_status == mfsd_pkg::ST_SYNC, "unknown frame status")
  `MFSD_ASSERT_NOW(a_err_power, out_valid && out_frame_status != mfsd_pkg::ST_GOOD, out_power_watts == '0, "error result carries power")
  `MFSD_ASSERT_NEXT_RST(a_rst_quiet, !rst_n, !out_valid, "result request right after reset")

endmodule

bind meter_frame_sync_deframer mfsd_checker u_mfsd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_power_watts  (out_power_watts),
  .out_frame_status (out_frame_status)
);
